[hdl/kvpg_pkg.sv]
// Shared constants, types and mixing functions of the key/value pair generator.
`timescale 1ns / 1ps

package kvpg_pkg;

	// Defaults and fixed limits
	localparam int TABLE_DEPTH_DEF = 2048;
	localparam int MAX_PART_LENGTH = 31;

	// Additive constants of the inject and remix steps
	localparam logic [63:0] INJECT_ADD = 64'd10042331536242289283;
	localparam logic [63:0] REMIX_ADD  = 64'd7015912586649315971;

	// Command codes
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_RESTART = 2'd1;
	localparam logic [1:0] CMD_GEN     = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_PRINTABLE = 3'd0;
	localparam logic [2:0] REG_KEY_WIDTH = 3'd1;
	localparam logic [2:0] REG_KEY_LEN   = 3'd2;
	localparam logic [2:0] REG_VAL_LEN   = 3'd3;
	localparam logic [2:0] REG_VAL_AGE   = 3'd4;
	localparam logic [2:0] REG_PERIOD    = 3'd5;
	localparam logic [2:0] REG_BASE      = 3'd6;
	localparam logic [2:0] REG_START     = 3'd7;

	// Status of the remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} kvpg_mod_stat_t;

	// Key width clamped to 2..8 bytes
	function automatic logic [3:0] eff_width(input logic [3:0] kwb);
		logic [3:0] w;
		if (kwb < 4'd2) begin
			w = 4'd2;
		end else if (kwb > 4'd8) begin
			w = 4'd8;
		end else begin
			w = kwb;
		end
		return w;
	endfunction

	// Mask of the key space for a clamped width
	function automatic logic [63:0] width_mask(input logic [3:0] w);
		logic [63:0] m;
		if (w >= 4'd8) begin
			m = '1;
		end else begin
			m = (64'd1 << {w[2:0], 3'b000}) - 64'd1;
		end
		return m;
	endfunction

	// Multiplier of the width-specific mix
	function automatic logic [63:0] mix_mult(input logic [3:0] w);
		logic [63:0] m;
		unique case (w)
			4'd2:    m = 64'd25693;
			4'd3:    m = 64'd5537317;
			4'd4:    m = 64'd1923730889;
			4'd5:    m = 64'd274992889273;
			4'd6:    m = 64'd70375646670269;
			4'd7:    m = 64'd23022548244171181;
			default: m = 64'd4613509448041658233;
		endcase
		return m;
	endfunction

	// Left shift of the width-specific mix
	function automatic logic [4:0] mix_shift(input logic [3:0] w);
		logic [4:0] s;
		unique case (w)
			4'd2:    s = 5'd7;
			4'd3:    s = 5'd12;
			4'd4:    s = 5'd15;
			4'd5:    s = 5'd13;
			4'd6:    s = 5'd15;
			4'd7:    s = 5'd4;
			default: s = 5'd25;
		endcase
		return s;
	endfunction

	// p xor (rotate-left-47(p) + constant)
	function automatic logic [63:0] remix(input logic [63:0] p);
		return p ^ ({p[16:0], p[63:17]} + REMIX_ADD);
	endfunction

	// Part length clamped to the longest part
	function automatic logic [4:0] eff_len(input logic [4:0] v);
		logic [4:0] l;
		if (v > 5'(MAX_PART_LENGTH)) begin
			l = 5'(MAX_PART_LENGTH);
		end else begin
			l = v;
		end
		return l;
	endfunction

	// 64-entry alphabet: '@', digits, lower case, upper case, '_'
	function automatic logic [7:0] alpha(input logic [5:0] i);
		logic [7:0] c;
		if (i == 6'd0) begin
			c = 8'h40;
		end else if (i <= 6'd10) begin
			c = 8'h30 + 8'(i - 6'd1);
		end else if (i <= 6'd36) begin
			c = 8'h61 + 8'(i - 6'd11);
		end else if (i <= 6'd62) begin
			c = 8'h41 + 8'(i - 6'd37);
		end else begin
			c = 8'h5F;
		end
		return c;
	endfunction

endpackage

[hdl/key_value_pair_generator_top.sv]
// Top level of the key/value pair generator: command sequencer, mix datapath, output stage.
//
//  channel   dir  handshake            payload
//  cfg       in   cfg_we               cfg_index[2:0], cfg_data[63:0]
//  in        in   in_valid / in_ready  command, table_index, table_value, skip_value
//  out       out  out_valid / out_ready data_word[63:0], is_value, last
//
// Load, restart and unused requests complete on acceptance. A generate request runs the
// inject steps (add, table read from the RAM port, mix, four steps of one shared 32x32
// multiplier, final shift), then per part a start state, the emission of each unit, an add
// and a remix state per printable remix, one or two remixes per binary word gap and an end
// state; the value part adds a seed add and a seed remix state. Stalls on out_ready hold
// the emitting state. When serial + 1 reaches period, the bit-serial remainder unit runs
// alongside the fill and in_ready stays low until it finishes.
// Reset clears control and configuration; the mixing table is undefined until loaded and gets
// no clearing pass. TABLE_DEPTH must be a power of two.
`timescale 1ns / 1ps

module key_value_pair_generator_top
	import kvpg_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [10:0] table_index,
	input  logic [10:0] table_value,
	input  logic        skip_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] data_word,
	output logic        is_value,
	output logic        last
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int IW = ((AW > 11) ? AW : 11) + 1;

	// Sequencer states
	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_ADD    = 5'd1;
	localparam logic [4:0] ST_RD     = 5'd2;
	localparam logic [4:0] ST_MIX    = 5'd3;
	localparam logic [4:0] ST_MUL0   = 5'd4;
	localparam logic [4:0] ST_MUL1   = 5'd5;
	localparam logic [4:0] ST_MUL2   = 5'd6;
	localparam logic [4:0] ST_MUL3   = 5'd7;
	localparam logic [4:0] ST_SHF    = 5'd8;
	localparam logic [4:0] ST_PSTART = 5'd9;
	localparam logic [4:0] ST_EMIT_C = 5'd10;
	localparam logic [4:0] ST_CADD   = 5'd11;
	localparam logic [4:0] ST_RMXC   = 5'd12;
	localparam logic [4:0] ST_TERM   = 5'd13;
	localparam logic [4:0] ST_EMIT_B = 5'd14;
	localparam logic [4:0] ST_RMXB   = 5'd15;
	localparam logic [4:0] ST_PEND   = 5'd16;
	localparam logic [4:0] ST_VADD   = 5'd17;
	localparam logic [4:0] ST_VRMX   = 5'd18;

	// Configuration registers
	logic        printable_q;
	logic [3:0]  kwb_q;
	logic [4:0]  klen_q;
	logic [4:0]  vlen_q;
	logic [31:0] age_q;
	logic [63:0] period_q;
	logic [63:0] base_q;
	logic [63:0] start_q;

	// Control state
	logic [4:0]  state_q;
	logic [63:0] serial_q;
	logic        part_q;
	logic        has_value_q;
	logic [4:0]  len_q;
	logic [6:0]  left_q;
	logic        out_valid_q;

	// Datapath registers
	logic [63:0] pt_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic [63:0] data_q;
	logic        is_value_q;
	logic        last_q;

	// Derived values
	logic [3:0]  w_eff;
	logic [6:0]  bits;
	logic [63:0] mask;
	logic [63:0] mult;
	logic [4:0]  shamt;
	logic [63:0] y_mix;
	logic [63:0] y_fin;
	logic [63:0] pt_remix;
	logic [4:0]  part_len;
	logic [63:0] serial_inc;

	logic        in_acc;
	logic        acc_gen;
	logic        wr_ok;
	logic        can_emit;
	logic        emit;
	logic [63:0] emit_word;
	logic        emit_last;
	logic        bin_last_part;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;

	logic        ram_we;
	logic        ram_re;
	logic [10:0] ram_rdata;

	logic           mod_start;
	kvpg_mod_stat_t mod_stat;
	logic [63:0]    mod_result;

	// Request acceptance
	assign in_ready = (state_q == ST_IDLE) && !mod_stat.busy;
	assign in_acc   = in_valid && in_ready;
	assign acc_gen  = in_acc && (command == CMD_GEN);
	assign wr_ok    = IW'(table_index) < IW'(TABLE_DEPTH);
	assign ram_we   = in_acc && (command == CMD_LOAD) && wr_ok;
	assign ram_re   = (state_q == ST_RD);

	// Width-dependent mix parameters
	assign w_eff = eff_width(kwb_q);
	assign bits  = {w_eff, 3'b000};
	assign mask  = width_mask(w_eff);
	assign mult  = mix_mult(w_eff);
	assign shamt = mix_shift(w_eff);

	// Table xor, mask and first xorshift
	always_comb begin
		logic [63:0] y;
		y     = (pt_q ^ {53'b0, ram_rdata}) & mask;
		y_mix = y ^ (y >> 1);
	end

	// Final masked shift-xor after the multiply
	always_comb begin
		logic [63:0] y;
		y     = acc_q & mask;
		y_fin = y ^ ((y << shamt) & mask);
	end

	assign pt_remix   = remix(pt_q);
	assign part_len   = part_q ? eff_len(vlen_q) : eff_len(klen_q);
	assign serial_inc = serial_q + 64'd1;

	// Shared 32x32 multiplier: low 64 bits of y * mult in three partial products
	always_comb begin
		unique case (state_q)
			ST_MUL1: begin
				mul_a = pt_q[31:0];
				mul_b = mult[63:32];
			end
			ST_MUL2: begin
				mul_a = pt_q[63:32];
				mul_b = mult[31:0];
			end
			default: begin
				mul_a = pt_q[31:0];
				mul_b = mult[31:0];
			end
		endcase
	end
	assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

	// Unit emission into the output register
	assign can_emit      = !out_valid_q || out_ready;
	assign bin_last_part = (len_q <= 5'd8);
	always_comb begin
		emit      = 1'b0;
		emit_word = '0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_EMIT_C: begin
				emit      = can_emit;
				emit_word = {56'b0, alpha(acc_q[5:0])};
			end
			ST_TERM: begin
				emit      = can_emit;
				emit_last = part_q || !has_value_q;
			end
			ST_EMIT_B: begin
				emit      = can_emit;
				emit_word = pt_q;
				emit_last = bin_last_part && (part_q || !has_value_q);
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Serial wrap: slow path through the remainder unit
	assign mod_start = acc_gen && (period_q != 64'd0) && !(serial_inc < period_q);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			printable_q <= 1'b0;
			kwb_q       <= 4'd8;
			klen_q      <= 5'd16;
			vlen_q      <= 5'd0;
			age_q       <= '0;
			period_q    <= 64'd65536;
			base_q      <= '0;
			start_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRINTABLE: printable_q <= cfg_data[0];
				REG_KEY_WIDTH: kwb_q       <= cfg_data[3:0];
				REG_KEY_LEN:   klen_q      <= cfg_data[4:0];
				REG_VAL_LEN:   vlen_q      <= cfg_data[4:0];
				REG_VAL_AGE:   age_q       <= cfg_data[31:0];
				REG_PERIOD:    period_q    <= cfg_data;
				REG_BASE:      base_q      <= cfg_data;
				default:       start_q     <= cfg_data;
			endcase
		end
	end

	// Serial counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_q <= '0;
		end else if (mod_stat.done) begin
			serial_q <= mod_result;
		end else if (in_acc && (command == CMD_RESTART)) begin
			serial_q <= (start_q < period_q) ? start_q : 64'd0;
		end else if (acc_gen) begin
			if (period_q == 64'd0) begin
				serial_q <= '0;
			end else if (serial_inc < period_q) begin
				serial_q <= serial_inc;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			part_q      <= 1'b0;
			has_value_q <= 1'b0;
			len_q       <= '0;
			left_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc_gen) begin
						state_q     <= ST_ADD;
						part_q      <= 1'b0;
						has_value_q <= !skip_value && (vlen_q != 5'd0);
					end
				end
				ST_ADD:  state_q <= ST_RD;
				ST_RD:   state_q <= ST_MIX;
				ST_MIX:  state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_SHF;
				ST_SHF:  state_q <= ST_PSTART;
				ST_PSTART: begin
					len_q  <= part_len;
					left_q <= bits;
					if (printable_q) begin
						state_q <= (part_len == 5'd0) ? ST_TERM : ST_EMIT_C;
					end else begin
						state_q <= (part_len == 5'd0) ? ST_PEND : ST_EMIT_B;
					end
				end
				ST_EMIT_C: begin
					if (can_emit) begin
						if (len_q == 5'd1) begin
							state_q <= ST_TERM;
						end else begin
							len_q  <= len_q - 5'd1;
							left_q <= left_q - 7'd6;
							if (left_q < 7'd12) begin
								state_q <= ST_CADD;
							end
						end
					end
				end
				ST_CADD: state_q <= ST_RMXC;
				ST_RMXC: begin
					left_q  <= bits;
					state_q <= ST_EMIT_C;
				end
				ST_TERM: begin
					if (can_emit) begin
						state_q <= ST_PEND;
					end
				end
				ST_EMIT_B: begin
					if (can_emit) begin
						if (bin_last_part) begin
							state_q <= ST_PEND;
						end else begin
							len_q   <= len_q - 5'd8;
							state_q <= ST_RMXB;
						end
					end
				end
				ST_RMXB: begin
					// Narrow keys remix twice before the second word, once afterwards
					if (left_q >= 7'd32) begin
						left_q  <= 7'd64;
						state_q <= ST_EMIT_B;
					end else begin
						left_q <= {left_q[5:0], 1'b0};
					end
				end
				ST_PEND: begin
					if (!part_q && has_value_q) begin
						part_q  <= 1'b1;
						state_q <= ST_VADD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_VADD: state_q <= ST_VRMX;
				ST_VRMX: state_q <= ST_PSTART;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Point, accumulator and product registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc_gen) begin
					pt_q <= base_q + serial_q;
				end
			end
			ST_ADD:  pt_q <= pt_q + INJECT_ADD;
			ST_MIX:  pt_q <= y_mix;
			ST_MUL0: prod_q <= mul_p;
			ST_MUL1: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			ST_MUL2: begin
				acc_q  <= acc_q + {prod_q[31:0], 32'b0};
				prod_q <= mul_p;
			end
			ST_MUL3: acc_q <= acc_q + {prod_q[31:0], 32'b0};
			ST_SHF:  pt_q <= y_fin;
			ST_PSTART: acc_q <= pt_q;
			ST_EMIT_C: begin
				if (can_emit) begin
					acc_q <= {6'b0, acc_q[63:6]};
				end
			end
			ST_CADD: pt_q <= pt_q + acc_q;
			ST_RMXC: begin
				pt_q  <= pt_remix;
				acc_q <= pt_remix;
			end
			ST_RMXB: pt_q <= pt_remix;
			ST_VADD: pt_q <= pt_q + {32'b0, age_q};
			ST_VRMX: pt_q <= pt_remix;
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_q     <= emit_word;
			is_value_q <= part_q;
			last_q     <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign data_word = data_q;
	assign is_value  = is_value_q;
	assign last      = last_q;

	// Mixing table
	kvpg_ram #(
		.WIDTH (11),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(table_index)),
		.wdata (table_value),
		.re    (ram_re),
		.raddr (pt_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Serial remainder unit
	kvpg_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (serial_inc),
		.divisor  (period_q),
		.stat     (mod_stat),
		.result   (mod_result)
	);

`ifndef SYNTHESIS
	// A generate request always enters the inject sequence
	a_gen_enters_inject: assert property (@(posedge clk) disable iff (!arst_n)
		acc_gen |=> state_q == ST_ADD)
		else $error("generate request did not start inject");

	// Output valid only rises from an emitting state
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EMIT_C || $past(state_q) == ST_TERM ||
			$past(state_q) == ST_EMIT_B))
		else $error("output valid rose outside an emitting state");

	// The remainder unit is started only by an accepted generate request
	a_mod_start_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mod_stat.busy) |-> $past(acc_gen))
		else $error("remainder unit started without a generate request");
`endif

endmodule

[hdl/kvpg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module kvpg_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/kvpg_mod.sv]
// Bit-serial 64-bit remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module kvpg_mod
	import kvpg_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [63:0]    dividend,
	input  logic [63:0]    divisor,
	output kvpg_mod_stat_t stat,
	output logic [63:0]    result
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] dvs_q;

	logic [64:0] trial;
	logic [64:0] diff;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dvd_q[63]};
	assign diff  = trial - {1'b0, dvs_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			if (!diff[64]) begin
				rem_q <= diff[63:0];
			end else begin
				rem_q <= trial[63:0];
			end
		end
	end

	assign stat.busy = busy_q | done_q;
	assign stat.done = done_q;
	assign result    = rem_q;

endmodule
